// ===== src/ssdm_pkg.sv =====
package ssdm_pkg;

  // Default sizes of the dictionary and the stream history
  localparam int NODE_COUNT_DEF    = 4096;
  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int ALPHABET_SIZE_DEF = 26;

  // Fixed field widths
  localparam int SYMBOL_W = 5;

  // Item operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== src/ssdm_ram.sv =====
module ssdm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/stream_suffix_dictionary_match_top.sv =====
// Load item: link read, then follow or allocate the child, then stage the result; a dropped
//   letter skips the link read. Query item: push the letter, read the root mark and newest letter,
//   then trie steps (at most the history depth), each a dependent link read, then mark read.
// Throughput: one item at a time; the next item is taken once the result is staged.
// Reset (rst_n low, synchronous): state clears, then a clearing pass writes zero to every
//   child link (marks cleared alongside); no item taken.
module stream_suffix_dictionary_match_top #(
  parameter int NODE_COUNT    = ssdm_pkg::NODE_COUNT_DEF,
  parameter int HISTORY_DEPTH = ssdm_pkg::HISTORY_DEPTH_DEF,
  parameter int ALPHABET_SIZE = ssdm_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [ssdm_pkg::SYMBOL_W-1:0] in_symbol,
  input  logic                          in_pattern_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_match,
  output logic                          out_table_full
);

  localparam int SW         = ssdm_pkg::SYMBOL_W;
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int NW         = $clog2(NODE_COUNT);          // node index
  localparam int NUW        = NW + 1;                      // node count, up to NODE_COUNT
  localparam int LAW        = $clog2(LINK_DEPTH);          // link store address
  localparam int HW         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW         = $clog2(HISTORY_DEPTH + 1);   // fill and walk count

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,    // sweep the link and mark stores to zero
    ST_IDLE,     // wait for an input transfer
    ST_LOAD_RD,  // look up the child link of the load cursor
    ST_LOAD_CHK, // follow or allocate the child
    ST_Q_RD,     // read the root mark and the newest letter
    ST_Q_CHK,    // test mark, history bound and letter; look up the link
    ST_Q_LINK,   // step to the child, read its mark and the next letter
    ST_DONE      // hand the result to the output register
  } state_t;

  state_t          state_r, state_nxt;
  logic [LAW-1:0]  clr_cnt_r, clr_cnt_nxt;

  // Dictionary load state
  logic [NUW-1:0]  nodes_used_r, nodes_used_nxt;
  logic [NW-1:0]   cursor_r, cursor_nxt;
  logic            ovf_r, ovf_nxt;

  // History ring pointers
  logic [HW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;

  // Per-item working registers
  logic [SW-1:0]   sym_r, sym_nxt;
  logic            last_r, last_nxt;
  logic [LAW-1:0]  link_addr_r, link_addr_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [FW-1:0]   walk_r, walk_nxt;
  logic [HW-1:0]   pos_r, pos_nxt;
  logic            res_match_r, res_match_nxt;
  logic            res_full_r, res_full_nxt;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic            out_match_r, out_match_nxt;
  logic            out_full_r, out_full_nxt;

  // Memory ports
  logic            link_we, link_re;
  logic [LAW-1:0]  link_waddr, link_raddr;
  logic [NW-1:0]   link_wdata, link_rdata;
  logic            term_we, term_re;
  logic [NW-1:0]   term_waddr, term_raddr;
  logic            term_wdata, term_rdata;
  logic            ring_we, ring_re;
  logic [HW-1:0]   ring_waddr, ring_raddr;
  logic [SW-1:0]   ring_wdata, ring_rdata;

  // Shared address unit: node * ALPHABET_SIZE + letter
  logic [NW-1:0]   mul_node;
  logic [SW-1:0]   mul_sym;
  logic [LAW-1:0]  mul_addr;

  // Load bookkeeping
  logic [NW-1:0]   cur_new;
  logic            ovf_new;
  logic            load_fin;
  logic            in_xfer;

  function automatic logic [HW-1:0] pos_prev(input logic [HW-1:0] p);
    return (p == '0) ? HW'(HISTORY_DEPTH - 1) : p - HW'(1);
  endfunction

  function automatic logic [HW-1:0] pos_next(input logic [HW-1:0] p);
    return (p == HW'(HISTORY_DEPTH - 1)) ? '0 : p + HW'(1);
  endfunction

  assign mul_addr = LAW'(mul_node) * LAW'(ALPHABET_SIZE) + LAW'(mul_sym);

  assign in_ready       = (state_r == ST_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_match      = out_match_r;
  assign out_table_full = out_full_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    nodes_used_nxt = nodes_used_r;
    cursor_nxt     = cursor_r;
    ovf_nxt        = ovf_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    link_addr_nxt  = link_addr_r;
    node_nxt       = node_r;
    walk_nxt       = walk_r;
    pos_nxt        = pos_r;
    res_match_nxt  = res_match_r;
    res_full_nxt   = res_full_r;
    out_match_nxt  = out_match_r;
    out_full_nxt   = out_full_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    mul_node = cursor_r;
    mul_sym  = sym_r;
    cur_new  = cursor_r;
    ovf_new  = ovf_r;
    load_fin = 1'b0;

    link_we    = 1'b0;
    link_waddr = link_addr_r;
    link_wdata = nodes_used_r[NW-1:0];
    link_re    = 1'b0;
    link_raddr = mul_addr;
    term_we    = 1'b0;
    term_waddr = cur_new;
    term_wdata = 1'b1;
    term_re    = 1'b0;
    term_raddr = node_r;
    ring_we    = 1'b0;
    ring_waddr = head_r;
    ring_wdata = in_symbol;
    ring_re    = 1'b0;
    ring_raddr = pos_prev(pos_r);

    case (state_r)
      ST_CLEAR: begin
        // Zero one link entry a cycle; the mark store rides along
        link_we    = 1'b1;
        link_waddr = clr_cnt_r;
        link_wdata = '0;
        term_we    = (32'(clr_cnt_r) < NODE_COUNT);
        term_waddr = clr_cnt_r[NW-1:0];
        term_wdata = 1'b0;
        clr_cnt_nxt = clr_cnt_r + LAW'(1);
        if (clr_cnt_r == LAW'(LINK_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          sym_nxt       = in_symbol;
          last_nxt      = in_pattern_end;
          res_match_nxt = 1'b0;
          res_full_nxt  = 1'b0;
          if (in_op == ssdm_pkg::OP_QUERY) begin
            // Push the letter and start the walk at the root
            ring_we   = 1'b1;
            head_nxt  = pos_next(head_r);
            pos_nxt   = pos_next(head_r);
            if (fill_r != FW'(HISTORY_DEPTH)) begin
              fill_nxt = fill_r + FW'(1);
            end
            node_nxt  = '0;
            walk_nxt  = '0;
            state_nxt = ST_Q_RD;
          end else begin
            state_nxt = ST_LOAD_RD;
          end
        end
      end
      ST_LOAD_RD: begin
        if (ovf_r || !(32'(sym_r) < ALPHABET_SIZE)) begin
          // Drop the letter; the cursor holds unless the letter closes the pattern
          load_fin = 1'b1;
        end else begin
          link_re       = 1'b1;
          link_addr_nxt = mul_addr;
          state_nxt     = ST_LOAD_CHK;
        end
      end
      ST_LOAD_CHK: begin
        if (link_rdata != '0) begin
          cur_new = link_rdata;
        end else if (nodes_used_r == NUW'(NODE_COUNT)) begin
          ovf_new = 1'b1;
        end else begin
          link_we        = 1'b1;
          cur_new        = nodes_used_r[NW-1:0];
          nodes_used_nxt = nodes_used_r + NUW'(1);
        end
        load_fin = 1'b1;
      end
      ST_Q_RD: begin
        term_re   = 1'b1;
        ring_re   = 1'b1;
        state_nxt = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        mul_node = node_r;
        mul_sym  = ring_rdata;
        if (term_rdata) begin
          res_match_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else if (walk_r >= fill_r) begin
          state_nxt = ST_DONE;
        end else if (!(32'(ring_rdata) < ALPHABET_SIZE)) begin
          // No edge carries this letter
          state_nxt = ST_DONE;
        end else begin
          link_re   = 1'b1;
          pos_nxt   = pos_prev(pos_r);
          state_nxt = ST_Q_LINK;
        end
      end
      ST_Q_LINK: begin
        if (link_rdata == '0) begin
          state_nxt = ST_DONE;
        end else begin
          node_nxt   = link_rdata;
          walk_nxt   = walk_r + FW'(1);
          term_re    = 1'b1;
          term_raddr = link_rdata;
          ring_re    = 1'b1;
          state_nxt  = ST_Q_CHK;
        end
      end
      ST_DONE: begin
        // Stage the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = res_match_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_fin) begin
      res_full_nxt = ovf_new;
      state_nxt    = ST_DONE;
      if (last_r) begin
        // Close the pattern: mark its node unless it overflowed or is empty
        term_we    = !ovf_new && (cur_new != '0);
        term_waddr = cur_new;
        cursor_nxt = '0;
        ovf_nxt    = 1'b0;
      end else begin
        cursor_nxt = cur_new;
        ovf_nxt    = ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      nodes_used_r <= NUW'(1);
      cursor_r     <= '0;
      ovf_r        <= 1'b0;
      head_r       <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      nodes_used_r <= nodes_used_nxt;
      cursor_r     <= cursor_nxt;
      ovf_r        <= ovf_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    link_addr_r <= link_addr_nxt;
    node_r      <= node_nxt;
    walk_r      <= walk_nxt;
    pos_r       <= pos_nxt;
    res_match_r <= res_match_nxt;
    res_full_r  <= res_full_nxt;
    out_match_r <= out_match_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Child links, one row of ALPHABET_SIZE entries per node
  ssdm_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (NW)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // Terminal marks, one per node
  ssdm_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (1)
  ) u_marks (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .re    (term_re),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  // History ring of stream letters
  ssdm_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (SW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule

// ===== src/ssdm_checker.sv =====
module ssdm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_op,
  input logic [ssdm_pkg::SYMBOL_W-1:0] in_symbol,
  input logic                          in_pattern_end,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_match,
  input logic                          out_table_full
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match) && $stable(out_table_full))
    else $error("result changed while stalled");

  // A waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_op) && $stable(in_symbol)
      && $stable(in_pattern_end))
    else $error("input item changed while waiting");

  // A result is either a query match or a load overflow, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_match && out_table_full))
    else $error("match and table_full both set");

  // Reset starts the clearing pass, which takes no item
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  // An accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transfer");

endmodule

bind stream_suffix_dictionary_match_top ssdm_checker u_ssdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_op          (in_op),
  .in_symbol      (in_symbol),
  .in_pattern_end (in_pattern_end),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_match      (out_match),
  .out_table_full (out_table_full)
);

// ===== verif/ssdm_result_checker.sv =====
module ssdm_result_checker #(
  parameter int NODE_COUNT    = ssdm_pkg::NODE_COUNT_DEF,
  parameter int HISTORY_DEPTH = ssdm_pkg::HISTORY_DEPTH_DEF,
  parameter int ALPHABET_SIZE = ssdm_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_op,
  input  logic [ssdm_pkg::SYMBOL_W-1:0] in_symbol,
  input  logic                          in_pattern_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_match,
  input  logic                          out_table_full,
  output int                            fail_count,
  output int                            pending,
  output int                            hit_count,
  output int                            full_count
);

  typedef struct packed {
    logic match;
    logic table_full;
  } match_result_t;

  // Reverse trie and stream history mirrored at the block's widths
  logic [11:0] child_link [NODE_COUNT*ALPHABET_SIZE];
  logic        terminal   [NODE_COUNT];
  logic [12:0] nodes_used;
  logic [11:0] cursor;
  logic        overflowed;
  logic [4:0]  ring [HISTORY_DEPTH];
  logic [7:0]  head;
  logic [8:0]  fill;

  match_result_t awaited_results[$];

  task automatic clear_dictionary();
    foreach (child_link[i]) child_link[i] = '0;
    foreach (terminal[i]) terminal[i] = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    nodes_used = 13'd1;
    cursor     = '0;
    overflowed = 1'b0;
    head       = '0;
    fill       = '0;
  endtask

  // Add one pattern letter; the pattern_end letter closes the pattern
  function automatic match_result_t insert_letter(logic [4:0] sym, logic last);
    match_result_t res;
    int            idx;
    int            nxt;
    if (!overflowed && sym < ALPHABET_SIZE) begin
      idx = int'(cursor) * ALPHABET_SIZE + int'(sym);
      nxt = int'(child_link[idx]);
      if (nxt == 0) begin
        if (nodes_used >= NODE_COUNT) begin
          overflowed = 1'b1;
        end else begin
          nxt             = int'(nodes_used);
          nodes_used      = nodes_used + 13'd1;
          child_link[idx] = 12'(nxt);
        end
      end
      if (!overflowed) cursor = 12'(nxt);
    end
    res.match      = 1'b0;
    res.table_full = overflowed;
    if (last) begin
      if (!overflowed && cursor != '0) terminal[cursor] = 1'b1;
      cursor     = '0;
      overflowed = 1'b0;
    end
    return res;
  endfunction

  // Push a stream letter, then walk the trie back through the history
  function automatic match_result_t push_and_walk(logic [4:0] sym);
    match_result_t res;
    int            node;
    int            steps;
    int            pos;
    int            nxt;
    logic [4:0]    letter;
    logic          done;
    ring[head] = sym;
    head       = 8'((int'(head) + 1) % HISTORY_DEPTH);
    if (fill < HISTORY_DEPTH) fill = fill + 9'd1;
    res   = '0;
    node  = 0;
    steps = 0;
    pos   = int'(head);
    done  = 1'b0;
    while (!done) begin
      if (terminal[node]) begin
        res.match = 1'b1;
        done      = 1'b1;
      end else if (steps >= int'(fill)) begin
        done = 1'b1;
      end else begin
        pos    = (pos + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
        letter = ring[pos];
        if (letter >= ALPHABET_SIZE) begin
          done = 1'b1;
        end else begin
          nxt = int'(child_link[node*ALPHABET_SIZE + int'(letter)]);
          if (nxt == 0) begin
            done = 1'b1;
          end else begin
            node  = nxt;
            steps = steps + 1;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic note_failure(string field, logic exp_bit, logic act_bit);
    fail_count = fail_count + 1;
    $error("%s: expected %0b, actual %0b", field, exp_bit, act_bit);
  endtask

  always @(posedge clk) begin
    match_result_t exp_res;
    if (!rst_n) begin
      clear_dictionary();
      awaited_results.delete();
      fail_count = 0;
      hit_count  = 0;
      full_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_op == ssdm_pkg::OP_LOAD)
          awaited_results.insert(awaited_results.size(),
                                 insert_letter(in_symbol, in_pattern_end));
        else
          awaited_results.insert(awaited_results.size(), push_and_walk(in_symbol));
      end
      if (out_valid && out_ready) begin
        if (out_match === 1'b1) hit_count = hit_count + 1;
        if (out_table_full === 1'b1) full_count = full_count + 1;
        if (awaited_results.size() == 0) begin
          fail_count = fail_count + 1;
          $error("unexpected result: match %0b, table_full %0b", out_match, out_table_full);
        end else begin
          exp_res = awaited_results[0];
          awaited_results.delete(0);
          if (out_match !== exp_res.match) note_failure("match", exp_res.match, out_match);
          if (out_table_full !== exp_res.table_full)
            note_failure("table_full", exp_res.table_full, out_table_full);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== verif/tb_stream_suffix_dictionary_match_top.sv =====
module tb_stream_suffix_dictionary_match_top;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The post-reset clearing pass counts too, since it takes no item.
  localparam int STALL_LIMIT = 400000;
  // Covers the longest walk (HISTORY_DEPTH trie steps), plus margin
  localparam int SETTLE_CYCLES = 600;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          in_op          = ssdm_pkg::OP_LOAD;
  logic [ssdm_pkg::SYMBOL_W-1:0] in_symbol      = '0;
  logic                          in_pattern_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic                          out_match;
  logic                          out_table_full;

  int fail_count;
  int pending;
  int hit_count;
  int full_count;

  // Idle percentages for each side, changed per phase
  int send_idle = 17;
  int recv_idle = 48;

  int n_items   = 0;
  int n_loads   = 0;
  int n_queries = 0;
  int stall_cycles = 0;

  always #2 clk = ~clk;

  stream_suffix_dictionary_match_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_pattern_end (in_pattern_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match      (out_match),
    .out_table_full (out_table_full)
  );

  ssdm_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_pattern_end (in_pattern_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match      (out_match),
    .out_table_full (out_table_full),
    .fail_count     (fail_count),
    .pending        (pending),
    .hit_count      (hit_count),
    .full_count     (full_count)
  );

  // Receiver: drop ready at random in recv_idle percent of cycles
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stream_suffix_dictionary_match_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item. Called at a falling edge, returns at the falling edge after
  // the transfer. Valid is only lowered when a gap is rolled, so back-to-back
  // items keep it high without a lower/raise in the same step.
  task automatic push_item(logic op, logic [4:0] sym, logic pend);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_symbol      <= sym;
    in_pattern_end <= pend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_items = n_items + 1;
    if (op == ssdm_pkg::OP_LOAD) n_loads = n_loads + 1;
    else n_queries = n_queries + 1;
  endtask

  // Load a random pattern, last letter first; the final item carries pattern_end
  task automatic load_pattern(int len, int hi);
    for (int i = 0; i < len; i++)
      push_item(ssdm_pkg::OP_LOAD, 5'($urandom_range(hi)), i == len - 1);
  endtask

  // Stream letters into the history; mostly from a narrow range so that hits
  // are frequent, now and then any 5-bit code including ones outside the alphabet
  task automatic query_burst(int cnt, int hi);
    logic [4:0] sym;
    repeat (cnt) begin
      sym = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(hi));
      push_item(ssdm_pkg::OP_QUERY, sym, 1'($urandom_range(1)));
    end
  endtask

  // One random episode: a well-formed pattern load, a run of queries, or a
  // stray item (which may split a pattern load or close one early)
  task automatic random_episode();
    int r;
    r = $urandom_range(99);
    if (r < 35)
      load_pattern($urandom_range(5, 1), ($urandom_range(9) == 0) ? 31 : 3);
    else if (r < 88)
      query_burst($urandom_range(12, 1), 3);
    else
      push_item(1'($urandom_range(1)), 5'($urandom_range(31)), 1'($urandom_range(1)));
  endtask

  // Hold off the sender until every awaited result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [4:0] deep_letter;
    int         stop_at;

    // Synchronous reset; the block then runs its clearing
    // pass and holds in_ready low until done
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- Directed part -----------------------------------------------------
    // Query into an empty dictionary and an empty history
    push_item(ssdm_pkg::OP_QUERY, 5'd0, 1'b0);
    // Empty pattern: pattern_end on an ignored letter while at the root
    push_item(ssdm_pkg::OP_LOAD, 5'd26, 1'b1);
    // Single letter pattern "b"
    push_item(ssdm_pkg::OP_LOAD, 5'd1, 1'b1);
    // Pattern "ab", last letter first
    push_item(ssdm_pkg::OP_LOAD, 5'd1, 1'b0);
    push_item(ssdm_pkg::OP_LOAD, 5'd0, 1'b1);
    // Pattern "dc" with an out-of-alphabet letter skipped in the middle
    push_item(ssdm_pkg::OP_LOAD, 5'd2, 1'b0);
    push_item(ssdm_pkg::OP_LOAD, 5'd31, 1'b0);
    push_item(ssdm_pkg::OP_LOAD, 5'd3, 1'b1);
    // Pattern "z" closed by pattern_end on an ignored letter
    push_item(ssdm_pkg::OP_LOAD, 5'd25, 1'b0);
    push_item(ssdm_pkg::OP_LOAD, 5'd30, 1'b1);
    // Pattern "ef" with a query slipped in between its letters
    push_item(ssdm_pkg::OP_LOAD, 5'd5, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd3, 1'b1);
    push_item(ssdm_pkg::OP_LOAD, 5'd4, 1'b1);
    // Stream that hits each pattern, and one out-of-alphabet letter that cuts the walk
    push_item(ssdm_pkg::OP_QUERY, 5'd0, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd1, 1'b1);
    push_item(ssdm_pkg::OP_QUERY, 5'd3, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd2, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd25, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd31, 1'b1);
    push_item(ssdm_pkg::OP_QUERY, 5'd1, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd4, 1'b0);
    push_item(ssdm_pkg::OP_QUERY, 5'd5, 1'b0);

    // ---- Random part, sender idles 17%, receiver 48% --------------------------
    stop_at = n_items + 200;
    while (n_items < stop_at) random_episode();
    drain_results();

    // ---- Swap idling: sender 48%, receiver 17% --------------------------------
    send_idle = 48;
    recv_idle = 17;
    // Deep walk: a pattern of one letter repeated HISTORY_DEPTH times, then a
    // stream of that letter. The walk is cut by the history fill until the ring
    // is full, then hits, and keeps hitting once the oldest letters wrap.
    deep_letter = 5'($urandom_range(25, 16));
    for (int i = 0; i < ssdm_pkg::HISTORY_DEPTH_DEF; i++)
      push_item(ssdm_pkg::OP_LOAD, deep_letter, i == ssdm_pkg::HISTORY_DEPTH_DEF - 1);
    repeat (ssdm_pkg::HISTORY_DEPTH_DEF + 4)
      push_item(ssdm_pkg::OP_QUERY, deep_letter, 1'($urandom_range(1)));
    stop_at = n_items + 150;
    while (n_items < stop_at) random_episode();
    drain_results();

    // ---- Neither side idles ---------------------------------------------------
    send_idle = 0;
    recv_idle = 0;
    // Grow the node table with long random patterns over the full alphabet
    stop_at = n_items + 100;
    while (n_items < stop_at) begin
      load_pattern($urandom_range(20, 12), 25);
      if ($urandom_range(9) == 0) query_burst($urandom_range(6, 1), 25);
    end
    // Keep mixing loads and queries on the grown table
    stop_at = n_items + 150;
    while (n_items < stop_at) random_episode();

    // ---- Wind down ------------------------------------------------------------
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d items: %0d pattern loads, %0d stream queries, deep history walk",
             n_items, n_loads, n_queries);
    $display("saw %0d suffix hits and %0d loads flagged with a full node table",
             hit_count, full_count);
    if (fail_count == 0) begin
      $display("stream_suffix_dictionary_match_top verification clean");
    end else begin
      $display("stream_suffix_dictionary_match_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ssdm_pkg.sv
src/ssdm_ram.sv
src/stream_suffix_dictionary_match_top.sv
src/ssdm_checker.sv
verif/ssdm_result_checker.sv
verif/tb_stream_suffix_dictionary_match_top.sv
